// ===== rtl/ssui_pkg.sv =====
// Shared types and constants for the sorted set union/intersection engine.
// Used by ssui_front, ssui_back and the top level; no dependencies.
`timescale 1ns / 1ps

package ssui_pkg;

    // Field widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;

    // Default list store depth
    localparam int LIST_DEPTH_DEF = 32;

    // Depths of the command queue and the result queue
    localparam int CMD_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH = 4;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_APPEND_L = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND_R = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN      = 2'd2;

    // Operation register codes
    localparam logic SET_OP_UNION = 1'b0;
    localparam logic SET_OP_INTER = 1'b1;

    // Classified command passed from front to back
    typedef enum logic [1:0] {
        OP_APPEND_L,
        OP_APPEND_R,
        OP_RUN
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op            op;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    // One result transaction
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               empty_res;
        logic               last;
        logic               overflow;
    } t_result;

    // Back-end sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_back_state;

endpackage

// ===== rtl/ssui_fifo.sv =====
// Small synchronous FIFO with queue-style push/full and pop/empty sides.
// Standalone; used for the command queue and the result queue.
`timescale 1ns / 1ps

module ssui_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = CNT_W'(r_cnt + 1'b1);
            2'b01:   n_cnt = CNT_W'(r_cnt - 1'b1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store data
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/ssui_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on ssui_pkg and ssui_fifo.
`timescale 1ns / 1ps

module ssui_front
    import ssui_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [VALUE_W-1:0] i_value,
    output t_cmd               o_cmd,
    output logic               o_cmd_empty,
    input  logic               i_cmd_pop
);

    t_cmd w_cmd;
    logic w_known;

    // Classify the mode; drop the unused code here
    always_comb begin
        w_cmd.value = i_value;
        w_cmd.op    = OP_RUN;
        w_known     = 1'b1;
        case (i_mode)
            MODE_APPEND_L: w_cmd.op = OP_APPEND_L;
            MODE_APPEND_R: w_cmd.op = OP_APPEND_R;
            MODE_RUN:      w_cmd.op = OP_RUN;
            default:       w_known  = 1'b0;
        endcase
    end

    ssui_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_known),
        .o_full  (o_full),
        .i_data  (w_cmd),
        .i_pop   (i_cmd_pop),
        .o_empty (o_cmd_empty),
        .o_data  (o_cmd)
    );

endmodule

// ===== rtl/ssui_back.sv =====
// Back end: list stores, counters, the operation register and the merge walk.
// Depends on ssui_pkg; consumes commands from ssui_front, feeds the result queue.
`timescale 1ns / 1ps

module ssui_back
    import ssui_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    output t_result o_res,
    output logic    o_res_push,
    input  logic    i_res_full
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    // List stores
    logic [VALUE_W-1:0] r_left  [LIST_DEPTH];
    logic [VALUE_W-1:0] r_right [LIST_DEPTH];

    t_back_state        r_state, n_state;
    logic               r_set_op;
    logic [CNT_W-1:0]   r_lcnt, n_lcnt;
    logic [CNT_W-1:0]   r_rcnt, n_rcnt;
    logic               r_dropped, n_dropped;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [VALUE_W-1:0] r_cur, n_cur;
    logic               r_pend, n_pend;
    logic               r_skip, n_skip;

    logic               w_left_we;
    logic               w_right_we;
    logic               w_l_ok;
    logic               w_r_ok;
    logic [VALUE_W-1:0] w_l_head;
    logic [VALUE_W-1:0] w_r_head;
    logic               w_skip_l;
    logic               w_skip_r;
    logic               w_r_lt_l;
    logic               w_heads_eq;
    logic               w_more;
    logic               w_pick;
    logic [VALUE_W-1:0] w_pick_val;

    assign o_cfg_ready = 1'b1;

    // Heads of both lists and their relations
    assign w_l_ok     = (r_i < r_lcnt);
    assign w_r_ok     = (r_j < r_rcnt);
    assign w_l_head   = r_left[r_i[IDX_W-1:0]];
    assign w_r_head   = r_right[r_j[IDX_W-1:0]];
    assign w_skip_l   = r_skip && w_l_ok && (w_l_head == r_cur);
    assign w_skip_r   = r_skip && w_r_ok && (w_r_head == r_cur);
    assign w_r_lt_l   = ($signed(w_r_head) < $signed(w_l_head));
    assign w_heads_eq = (w_l_head == w_r_head);

    // Select whether a new value is taken this step, and which one
    always_comb begin
        if (r_set_op == SET_OP_INTER) begin
            w_more     = w_l_ok && w_r_ok;
            w_pick     = w_heads_eq;
            w_pick_val = w_l_head;
        end else begin
            w_more     = w_l_ok || w_r_ok;
            w_pick     = 1'b1;
            w_pick_val = (!w_r_ok || (w_l_ok && !w_r_lt_l)) ? w_l_head : w_r_head;
        end
    end

    // Sequencer: execute appends, walk both lists on a run
    always_comb begin
        n_state    = r_state;
        n_lcnt     = r_lcnt;
        n_rcnt     = r_rcnt;
        n_dropped  = r_dropped;
        n_i        = r_i;
        n_j        = r_j;
        n_cur      = r_cur;
        n_pend     = r_pend;
        n_skip     = r_skip;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{value: r_cur, empty_res: 1'b0, last: 1'b0, overflow: r_dropped};
        w_left_we  = 1'b0;
        w_right_we = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_APPEND_L: begin
                            if (r_lcnt < CNT_W'(LIST_DEPTH)) begin
                                w_left_we = 1'b1;
                                n_lcnt    = CNT_W'(r_lcnt + 1'b1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        OP_APPEND_R: begin
                            if (r_rcnt < CNT_W'(LIST_DEPTH)) begin
                                w_right_we = 1'b1;
                                n_rcnt     = CNT_W'(r_rcnt + 1'b1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_WALK;
                            n_i     = '0;
                            n_j     = '0;
                            n_pend  = 1'b0;
                            n_skip  = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // Hold everything while the result queue is full
                if (!i_res_full) begin
                    if (w_skip_l || w_skip_r) begin
                        // Drop repeats of the value just taken
                        if (w_skip_l) n_i = CNT_W'(r_i + 1'b1);
                        if (w_skip_r) n_j = CNT_W'(r_j + 1'b1);
                    end else if (w_more) begin
                        n_skip = 1'b0;
                        if (w_pick) begin
                            // Release the previous value, keep the new one pending
                            o_res_push = r_pend;
                            n_cur      = w_pick_val;
                            n_pend     = 1'b1;
                            n_skip     = 1'b1;
                            if (w_l_ok && (w_l_head == w_pick_val)) n_i = CNT_W'(r_i + 1'b1);
                            if (w_r_ok && (w_r_head == w_pick_val)) n_j = CNT_W'(r_j + 1'b1);
                        end else if (!w_r_lt_l) begin
                            n_i = CNT_W'(r_i + 1'b1);
                        end else begin
                            n_j = CNT_W'(r_j + 1'b1);
                        end
                    end else begin
                        // End of run: last item, or the empty marker
                        o_res_push = 1'b1;
                        o_res      = '{value:     r_pend ? r_cur : '0,
                                       empty_res: !r_pend,
                                       last:      1'b1,
                                       overflow:  r_dropped};
                        n_lcnt     = '0;
                        n_rcnt     = '0;
                        n_dropped  = 1'b0;
                        n_pend     = 1'b0;
                        n_skip     = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_set_op  <= SET_OP_UNION;
            r_lcnt    <= '0;
            r_rcnt    <= '0;
            r_dropped <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_pend    <= 1'b0;
            r_skip    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lcnt    <= n_lcnt;
            r_rcnt    <= n_rcnt;
            r_dropped <= n_dropped;
            r_i       <= n_i;
            r_j       <= n_j;
            r_pend    <= n_pend;
            r_skip    <= n_skip;
            if (i_cfg_valid) begin
                r_set_op <= i_cfg_data;
            end
        end
    end

    // Hold the current value; no reset needed
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // Write appended values at the fill position
    always_ff @(posedge i_clk) begin
        if (w_left_we) begin
            r_left[r_lcnt[IDX_W-1:0]] <= i_cmd.value;
        end
        if (w_right_we) begin
            r_right[r_rcnt[IDX_W-1:0]] <= i_cmd.value;
        end
    end

endmodule

// ===== rtl/sorted_set_union_intersection.sv =====
// Sorted set union/intersection engine, top level.
// Appends: one transaction per cycle while the command queue is not full, stored while the
//   back end is idle; the command queue fills and raises full while a run walks.
// Run: taken from the head of the command queue while idle, then one step per cycle (at most
//   left_count + right_count + 1), held while the result queue is full; each value is queued
//   at the next pick or the end step.
// Reset: queues empty, counts, drop flag and operation (union) cleared; stores kept.
`timescale 1ns / 1ps

module sorted_set_union_intersection
    import ssui_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic                      o_empty_res,
    output logic                      o_last,
    output logic                      o_overflow,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data
);

    t_cmd    w_cmd;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    t_result w_res_in;
    logic    w_res_push;
    logic    w_res_full;
    t_result w_res_out;

    // Accept and classify input transactions
    ssui_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Execute appends and merge runs
    ssui_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res_in),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    // Queue results toward the consumer
    ssui_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_full  (w_res_full),
        .i_data  (w_res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_out)
    );

    assign o_result_value = w_res_out.value;
    assign o_empty_res    = w_res_out.empty_res;
    assign o_last         = w_res_out.last;
    assign o_overflow     = w_res_out.overflow;

endmodule

// ===== sim/tb_sorted_set_union_intersection.sv =====
// Self-checking testbench for the sorted set union/intersection engine.
// Depends on ssui_pkg and sorted_set_union_intersection from the rtl folder.
`timescale 1ns / 1ps

module tb_sorted_set_union_intersection
    import ssui_pkg::*;
;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int DEPTH         = LIST_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 60;
    localparam int IDLE_PCT      = 31;
    localparam int VAL_MIN       = -2147483647 - 1;
    localparam int VAL_MAX       = 2147483647;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      push           = 1'b0;
    logic                      full;
    logic [MODE_W-1:0]         i_mode         = MODE_APPEND_L;
    logic signed [VALUE_W-1:0] i_value        = '0;
    logic                      empty;
    logic                      pop            = 1'b0;
    logic signed [VALUE_W-1:0] o_result_value;
    logic                      o_empty_res;
    logic                      o_last;
    logic                      o_overflow;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_data     = 1'b0;

    // Shadow copy of the engine state
    int      left_list[$];
    int      right_list[$];
    bit      dropped       = 1'b0;
    logic    set_op        = SET_OP_UNION;
    t_result expected_results[$];

    int error_count = 0;
    int cycle_count = 0;
    bit steady      = 1'b0;

    sorted_set_union_intersection #(
        .LIST_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .empty         (empty),
        .pop           (pop),
        .o_result_value(o_result_value),
        .o_empty_res   (o_empty_res),
        .o_last        (o_last),
        .o_overflow    (o_overflow),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_result make_result(input int v, input logic is_empty);
        t_result r;
        r.value     = v;
        r.empty_res = is_empty;
        r.last      = 1'b0;
        r.overflow  = dropped;
        return r;
    endfunction

    // Walk both lists the way the engine does and queue the results of one run
    task automatic merge_lists();
        int      i, j, n, nl, nr;
        t_result run_out[$];
        i  = 0;
        j  = 0;
        nl = left_list.size();
        nr = right_list.size();
        if (set_op == SET_OP_UNION) begin
            while (i < nl || j < nr) begin
                if (j >= nr || (i < nl && !(right_list[j] < left_list[i])))
                    n = left_list[i];
                else
                    n = right_list[j];
                while (i < nl && left_list[i] == n) i++;
                while (j < nr && right_list[j] == n) j++;
                run_out.push_back(make_result(n, 1'b0));
            end
        end else begin
            while (i < nl && j < nr) begin
                if (left_list[i] == right_list[j]) begin
                    n = left_list[i];
                    run_out.push_back(make_result(n, 1'b0));
                    do i++; while (i < nl && left_list[i] == n);
                    do j++; while (j < nr && right_list[j] == n);
                end else if (left_list[i] < right_list[j]) begin
                    do i++; while (i < nl && left_list[i] < right_list[j]);
                end else begin
                    do j++; while (j < nr && right_list[j] < left_list[i]);
                end
            end
        end
        if (run_out.size() == 0)
            run_out.push_back(make_result(0, 1'b1));
        run_out[run_out.size() - 1].last = 1'b1;
        foreach (run_out[k])
            expected_results.push_back(run_out[k]);
    endtask

    // Update the shadow state for one accepted transaction
    task automatic predict_item(input logic [MODE_W-1:0] m, input int v);
        case (m)
            MODE_APPEND_L: begin
                if (left_list.size() < DEPTH) left_list.push_back(v);
                else dropped = 1'b1;
            end
            MODE_APPEND_R: begin
                if (right_list.size() < DEPTH) right_list.push_back(v);
                else dropped = 1'b1;
            end
            MODE_RUN: begin
                merge_lists();
                left_list.delete();
                right_list.delete();
                dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Compare one popped result with the oldest expectation
    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: value %0d empty_res %0b last %0b overflow %0b",
                   o_result_value, o_empty_res, o_last, o_overflow);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (o_result_value !== want.value) begin
                $error("result_value: expected %0d, got %0d", $signed(want.value),
                       o_result_value);
                error_count++;
            end
            if (o_empty_res !== want.empty_res) begin
                $error("empty_res: expected %0b, got %0b", want.empty_res, o_empty_res);
                error_count++;
            end
            if (o_last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, o_last);
                error_count++;
            end
            if (o_overflow !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, o_overflow);
                error_count++;
            end
        end
    endtask

    // Pop results with random stalls and check each transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_result();
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Push one item; push stays high on return so back-to-back items stream
    task automatic send_item(input logic [MODE_W-1:0] m, input int v);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_mode  <= m;
        i_value <= v;
        do @(posedge i_clk); while (full);
        predict_item(m, v);
    endtask

    // Drop push, wait for all results, then let queued appends settle
    task automatic wait_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_set_op(input logic op);
        wait_drain();
        i_cfg_data  <= op;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        set_op = op;
    endtask

    // Append both lists in a random interleave, then run the merge
    task automatic load_and_run(input int l[$], input int r[$]);
        while (l.size() != 0 || r.size() != 0) begin
            if (r.size() == 0 || (l.size() != 0 && $urandom_range(1) == 0))
                send_item(MODE_APPEND_L, l.pop_front());
            else
                send_item(MODE_APPEND_R, r.pop_front());
        end
        send_item(MODE_RUN, $urandom);
    endtask

    function automatic int pick_value(input int base, input bit narrow);
        case ($urandom_range(15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            default: return narrow ? base + $urandom_range(0, 12) : $urandom;
        endcase
    endfunction

    task automatic test_union();
        int l[$];
        int r[$];
        write_set_op(SET_OP_UNION);
        l = {VAL_MIN, -1, 5, 5};
        r = {-1, 3, 5, VAL_MAX};
        load_and_run(l, r);
    endtask

    // Unused mode code must neither append nor emit
    task automatic test_unused_mode();
        send_item(MODE_APPEND_L, 4);
        send_item(MODE_UNUSED, -1);
        send_item(MODE_APPEND_R, 4);
        send_item(MODE_RUN, 0);
    endtask

    task automatic test_empty_result();
        int l[$];
        int r[$];
        send_item(MODE_RUN, -1);
        write_set_op(SET_OP_INTER);
        l = {1};
        r = {2};
        load_and_run(l, r);
    endtask

    task automatic test_intersection();
        int l[$];
        int r[$];
        l = {VAL_MIN, 2, 2, 7};
        r = {2, 7, 7, VAL_MAX};
        load_and_run(l, r);
    endtask

    task automatic test_unsorted();
        int l[$];
        int r[$];
        l = {9, -4, 20};
        r = {20, 3};
        load_and_run(l, r);
    endtask

    // Fill both stores past depth, then check the flag clears on the next run
    task automatic test_overflow();
        int l[$];
        int r[$];
        write_set_op(SET_OP_UNION);
        steady = 1'b1;
        for (int k = 0; k < DEPTH + 2; k++) l.push_back(2 * k - 20);
        for (int k = 0; k < DEPTH + 1; k++) r.push_back(3 * k - 20);
        load_and_run(l, r);
        l = {1};
        r.delete();
        load_and_run(l, r);
        steady = 1'b0;
    endtask

    task automatic test_random();
        int                sent, batch, kind, nl, nr, base;
        bit                narrow;
        logic [MODE_W-1:0] m;
        int                l[$];
        int                r[$];
        sent  = 0;
        batch = 0;
        while (sent < RANDOM_ITEMS) begin
            if (batch % 4 == 0) write_set_op(1'($urandom_range(1)));
            steady = (batch >= 5 && batch < 10);
            l.delete();
            r.delete();
            kind = $urandom_range(99);
            if (kind < 90) begin
                // mostly short lists, now and then up to and past the depth
                if ($urandom_range(9) == 0) begin
                    nl = $urandom_range(DEPTH - 2, DEPTH + 2);
                    nr = $urandom_range(DEPTH - 2, DEPTH + 2);
                end else begin
                    nl = $urandom_range(0, 8);
                    nr = $urandom_range(0, 8);
                end
                base   = $urandom;
                narrow = ($urandom_range(3) != 0);
                repeat (nl) l.push_back(pick_value(base, narrow));
                repeat (nr) r.push_back(pick_value(base, narrow));
                // sorted lists most of the time, raw order otherwise
                if (kind < 75) begin
                    l.sort();
                    r.sort();
                end
                load_and_run(l, r);
                sent += nl + nr + 1;
            end else begin
                // noise over all mode codes
                repeat ($urandom_range(1, 6)) begin
                    m = MODE_W'($urandom_range(3));
                    send_item(m, $urandom);
                    if (m != MODE_UNUSED) sent++;
                end
            end
            batch++;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_union();
        test_unused_mode();
        test_empty_result();
        test_intersection();
        test_unsorted();
        test_overflow();
        test_random();
        wait_drain();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ssui_pkg.sv
rtl/ssui_fifo.sv
rtl/ssui_front.sv
rtl/ssui_back.sv
rtl/sorted_set_union_intersection.sv
sim/tb_sorted_set_union_intersection.sv
